/* rtl/mco_pkg.sv */
// Shared types, constants and the control program of the circle outline sequencer.
package mco_pkg;

    localparam int CRD_W      = 13;
    localparam int PNT_W      = 14;
    localparam int RAD_W      = 4;
    localparam int GRID_W     = 13;
    localparam int OFS_W      = 6;
    localparam int ERR_W      = 8;
    localparam int ITER_W     = 3;
    localparam int STEP_W     = 4;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_ADDR_W = 1;
    localparam int MAX_RADIUS_DEF = 10;

    localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 1'b1;
    localparam logic [GRID_W-1:0]     GRID_RESET      = 13'd256;

    localparam logic [STEP_W-1:0] STEP_WAIT  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK = 4'd1;
    localparam logic [STEP_W-1:0] STEP_LOOP  = 4'd2;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_SKIP,
        JMP_LOOP
    } jmp_t;

    typedef struct packed {
        logic load;
        logic emit;
        logic update;
        logic swap;
        logic neg_u;
        logic neg_v;
        jmp_t jmp;
    } ctrl_t;

    typedef struct packed {
        logic in_fire;
        logic out_free;
        logic skip;
        logic more;
    } stat_t;

    function automatic ctrl_t rom_word(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '{load: 1'b0, emit: 1'b0, update: 1'b0, swap: 1'b0,
              neg_u: 1'b0, neg_v: 1'b0, jmp: JMP_NEXT};
        unique case (step)
            4'd0: begin w.load = 1'b1; w.jmp = JMP_WAIT_IN; end
            4'd1: begin w.jmp = JMP_SKIP; end
            4'd2: begin w.emit = 1'b1; w.neg_v = 1'b1; end
            4'd3: begin w.emit = 1'b1; end
            4'd4: begin w.emit = 1'b1; w.neg_u = 1'b1; w.neg_v = 1'b1; end
            4'd5: begin w.emit = 1'b1; w.neg_u = 1'b1; end
            4'd6: begin w.emit = 1'b1; w.swap = 1'b1; w.neg_v = 1'b1; end
            4'd7: begin w.emit = 1'b1; w.swap = 1'b1; end
            4'd8: begin
                w.emit = 1'b1; w.swap = 1'b1; w.neg_u = 1'b1; w.neg_v = 1'b1;
            end
            4'd9: begin
                w.emit = 1'b1; w.swap = 1'b1; w.neg_u = 1'b1;
                w.update = 1'b1; w.jmp = JMP_LOOP;
            end
            default: begin w.jmp = JMP_LOOP; end
        endcase
        return w;
    endfunction

endpackage

/* rtl/mco_seq.sv */
// Step counter and control store of the circle outline sequencer.
module mco_seq
    import mco_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  stat_t stat,
    output ctrl_t ctrl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    assign ctrl = rom_word(step_reg);

    always_comb begin
        step_next = step_reg;
        unique case (ctrl.jmp)
            JMP_NEXT: begin
                if (!ctrl.emit || stat.out_free) begin
                    step_next = step_reg + 1'b1;
                end
            end
            JMP_WAIT_IN: begin
                if (stat.in_fire) begin
                    step_next = STEP_CHECK;
                end
            end
            JMP_SKIP: begin
                step_next = stat.skip ? STEP_WAIT : STEP_LOOP;
            end
            JMP_LOOP: begin
                if (!ctrl.emit || stat.out_free) begin
                    step_next = stat.more ? STEP_LOOP : STEP_WAIT;
                end
            end
            default: step_next = STEP_WAIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

/* rtl/mco_dp.sv */
// Datapath: grid registers, midpoint error terms and the output register.
module mco_dp
    import mco_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  ctrl_t                    ctrl,
    output stat_t                    stat,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [GRID_W-1:0]        cfg_wdata,
    input  logic                     in_valid,
    input  logic signed [CRD_W-1:0]  center_x,
    input  logic signed [CRD_W-1:0]  center_y,
    input  logic [RAD_W-1:0]         circle_radius,
    input  logic                     over_ui,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [PNT_W-1:0]  point_x,
    output logic signed [PNT_W-1:0]  point_y,
    output logic                     last
);

    localparam logic [RAD_W-1:0] RAD_MAX = RAD_W'(MAX_RADIUS);

    logic [GRID_W-1:0] grid_w_reg, grid_h_reg;
    logic signed [CRD_W-1:0] cx_reg, cy_reg;
    logic signed [OFS_W-1:0] x_reg, y_reg;
    logic signed [ERR_W-1:0] err_reg, tx_reg, ty_reg, diam_reg;
    logic [ITER_W-1:0] iter_reg;
    logic skip_reg;
    logic out_valid_reg;
    logic signed [PNT_W-1:0] px_reg, py_reg;
    logic last_reg;

    logic [RAD_W-1:0] r_sat;
    logic signed [OFS_W-1:0] nx, ny, u_sel, v_sel, u_off, v_off;
    logic signed [ERR_W-1:0] e1, nerr, ntx, nty;
    logic out_free;
    logic in_skip;

    assign r_sat = (circle_radius > RAD_MAX) ? RAD_MAX : circle_radius;
    assign in_skip = over_ui || center_x[CRD_W-1] || center_y[CRD_W-1]
        || ({1'b0, center_x[CRD_W-2:0]} >= grid_w_reg)
        || ({1'b0, center_y[CRD_W-2:0]} >= grid_h_reg);

    always_comb begin
        nx   = x_reg;
        ny   = y_reg;
        ntx  = tx_reg;
        nty  = ty_reg;
        e1   = err_reg;
        if (err_reg <= 0) begin
            ny  = y_reg + 6'sd1;
            e1  = err_reg + ty_reg;
            nty = ty_reg + 8'sd2;
        end
        nerr = e1;
        if (e1 > 0) begin
            nx   = x_reg - 6'sd1;
            ntx  = tx_reg + 8'sd2;
            nerr = e1 + ntx - diam_reg;
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign u_sel = ctrl.swap ? y_reg : x_reg;
    assign v_sel = ctrl.swap ? x_reg : y_reg;
    assign u_off = ctrl.neg_u ? -u_sel : u_sel;
    assign v_off = ctrl.neg_v ? -v_sel : v_sel;

    assign stat.in_fire  = ctrl.load && in_valid;
    assign stat.out_free = out_free;
    assign stat.skip     = skip_reg || (x_reg < y_reg);
    assign stat.more     = (nx >= ny) && (iter_reg != {ITER_W{1'b1}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_w_reg    <= GRID_RESET;
            grid_h_reg    <= GRID_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_GRID_WIDTH:  grid_w_reg <= cfg_wdata;
                    REG_GRID_HEIGHT: grid_h_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (ctrl.emit && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stat.in_fire) begin
            cx_reg   <= center_x;
            cy_reg   <= center_y;
            skip_reg <= in_skip;
            x_reg    <= OFS_W'({2'b00, r_sat}) - 1'sd1;
            y_reg    <= '0;
            tx_reg   <= 8'sd1;
            ty_reg   <= 8'sd1;
            diam_reg <= ERR_W'({r_sat, 1'b0});
            err_reg  <= 8'sd1 - ERR_W'({r_sat, 1'b0});
            iter_reg <= '0;
        end else if (ctrl.update && out_free) begin
            x_reg    <= nx;
            y_reg    <= ny;
            tx_reg   <= ntx;
            ty_reg   <= nty;
            err_reg  <= nerr;
            iter_reg <= iter_reg + 1'b1;
        end
        if (ctrl.emit && out_free) begin
            px_reg   <= PNT_W'(cx_reg) + PNT_W'(u_off);
            py_reg   <= PNT_W'(cy_reg) + PNT_W'(v_off);
            last_reg <= ctrl.update && !stat.more;
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x   = px_reg;
    assign point_y   = py_reg;
    assign last      = last_reg;

endmodule

/* rtl/midpoint_circle_outline.sv */
// Top level of the midpoint circle outline generator.
// One request yields up to 64 outline points, one per cycle while the sink takes them:
// a circle of radius r runs at most eight iterations of eight points each, after the
// request is loaded and checked; the last emit step returns straight to the wait step.
// The step counter walks a ten-word control program; each emit step fills the single
// output register. Requests with the over-UI flag, a center off the grid or radius zero
// give no points.
module midpoint_circle_outline
    import mco_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [GRID_W-1:0]       cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // center_x[12:0], center_y[25:13], circle_radius[29:26], over_ui[30], zero[31]
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // point_x[13:0], point_y[27:14], zero[31:28]
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    output logic                    m_tlast
);

    ctrl_t ctrl;
    stat_t stat;
    logic signed [PNT_W-1:0] point_x, point_y;

    mco_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    mco_dp #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (ctrl),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (s_tvalid),
        .center_x      (s_tdata[12:0]),
        .center_y      (s_tdata[25:13]),
        .circle_radius (s_tdata[29:26]),
        .over_ui       (s_tdata[30]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .point_x       (point_x),
        .point_y       (point_y),
        .last          (m_tlast)
    );

    assign s_tready = ctrl.load;
    assign m_tdata  = {4'b0000, point_y, point_x};

endmodule

/* tb/mco_outline_checker.sv */
// Checker for the circle outline generator: predicts outline points and compares the result stream.
`timescale 1ns / 1ps
module mco_outline_checker
    import mco_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [GRID_W-1:0]       cfg_wdata,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [OUT_TDATA_W-1:0]  m_tdata,
    input  logic                    m_tlast,
    output int                      fail_count,
    output int                      expected_left
);

    localparam int MAX_POINTS = 64;

    typedef struct packed {
        logic [PNT_W-1:0] px;
        logic [PNT_W-1:0] py;
        logic             lst;
    } point_t;

    point_t            outline_q[$];
    logic [GRID_W-1:0] grid_w = GRID_RESET;
    logic [GRID_W-1:0] grid_h = GRID_RESET;
    int                mismatches = 0;

    task automatic predict_outline(input logic [IN_TDATA_W-1:0] req);
        logic signed [CRD_W-1:0] sx;
        logic signed [CRD_W-1:0] sy;
        int     cx, cy, r, x, y, tx, ty, err, diam, n;
        int     ox[8];
        int     oy[8];
        point_t pts[MAX_POINTS];
        sx = req[CRD_W-1:0];
        sy = req[2*CRD_W-1:CRD_W];
        cx = sx;
        cy = sy;
        r  = req[2*CRD_W+RAD_W-1:2*CRD_W];
        n  = 0;
        if (req[2*CRD_W+RAD_W] || cx < 0 || cx >= int'(grid_w) ||
            cy < 0 || cy >= int'(grid_h))
            return;
        if (r > MAX_RADIUS)
            r = MAX_RADIUS;
        diam = 2 * r;
        x    = r - 1;
        y    = 0;
        tx   = 1;
        ty   = 1;
        err  = tx - diam;
        while (x >= y && n + 8 <= MAX_POINTS) begin
            ox = '{x, x, -x, -x, y, y, -y, -y};
            oy = '{-y, y, -y, y, -x, x, -x, x};
            for (int k = 0; k < 8; k++) begin
                pts[n].px  = PNT_W'(cx + ox[k]);
                pts[n].py  = PNT_W'(cy + oy[k]);
                pts[n].lst = 1'b0;
                n++;
            end
            if (err <= 0) begin
                y++;
                err += ty;
                ty  += 2;
            end
            if (err > 0) begin
                x--;
                tx  += 2;
                err += tx - diam;
            end
        end
        for (int i = 0; i < n; i++) begin
            pts[i].lst = (i == n - 1);
            outline_q.insert(outline_q.size(), pts[i]);
        end
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        point_t want;
        if (!aresetn) begin
            grid_w = GRID_RESET;
            grid_h = GRID_RESET;
            outline_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (outline_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: point transaction, expected none, actual (%0d, %0d) last %0d",
                             $time, $signed(m_tdata[PNT_W-1:0]),
                             $signed(m_tdata[2*PNT_W-1:PNT_W]), m_tlast);
                end else begin
                    want = outline_q.pop_front();
                    check_field("point_x", $signed(want.px), $signed(m_tdata[PNT_W-1:0]));
                    check_field("point_y", $signed(want.py),
                                $signed(m_tdata[2*PNT_W-1:PNT_W]));
                    check_field("last", want.lst, m_tlast);
                    check_field("pad", 0, m_tdata[OUT_TDATA_W-1:2*PNT_W]);
                end
            end
            if (s_tvalid && s_tready)
                predict_outline(s_tdata);
            if (cfg_we) begin
                case (cfg_addr)
                    REG_GRID_WIDTH:  grid_w = cfg_wdata;
                    REG_GRID_HEIGHT: grid_h = cfg_wdata;
                    default: ;
                endcase
            end
        end
        fail_count    <= mismatches;
        expected_left <= outline_q.size();
    end

endmodule

/* tb/tb_midpoint_circle_outline.sv */
// Testbench top for the circle outline generator: clock, reset, stimulus, sink and verdict.
`timescale 1ns / 1ps
module tb_midpoint_circle_outline;
    import mco_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 80;
    localparam int SETTLE       = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 35;
    localparam int MAX_CENTER   = 4096;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = REG_GRID_WIDTH;
    logic [GRID_W-1:0]      cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b1;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    int fail_count;
    int expected_left;
    int cycles        = 0;
    int requests      = 0;
    int grid_settings = 1;
    int stall_pct     = 0;
    int gap_pct       = 0;
    bit quiet         = 1'b0;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;

    midpoint_circle_outline u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    mco_outline_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pack_request(input int cx, input int cy,
                                                            input int rad, input bit ui);
        return {1'b0, ui, rad[RAD_W-1:0], cy[CRD_W-1:0], cx[CRD_W-1:0]};
    endfunction

    task automatic offer_request(input logic [IN_TDATA_W-1:0] req);
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do @(posedge aclk); while (!s_tready);
        requests++;
        if (!quiet && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained(input int extra);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_left != 0);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic set_grid(input int gw, input int gh);
        wait_drained(SETTLE);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_GRID_WIDTH;
        cfg_wdata <= gw[GRID_W-1:0];
        @(posedge aclk);
        cfg_addr  <= REG_GRID_HEIGHT;
        cfg_wdata <= gh[GRID_W-1:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
        grid_settings++;
    endtask

    // Mostly in-grid requests with random radius; the rest is raw noise.
    task automatic random_phase(input int gw, input int gh, input int n_items);
        int cx, cy;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 3) != 0) begin
                cx = $urandom_range(0, (gw > MAX_CENTER ? MAX_CENTER : gw) - 1);
                cy = $urandom_range(0, (gh > MAX_CENTER ? MAX_CENTER : gh) - 1);
                offer_request(pack_request(cx, cy, $urandom_range(1, 15), 1'b0));
            end else begin
                offer_request($urandom & 32'h7FFF_FFFF);
            end
        end
    endtask

    initial begin : sink
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
                m_tready <= 1'b1;
            end else if (!quiet && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int gw;
        int gh;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        stall_pct = 10;
        gap_pct   = 15;
        offer_request(pack_request(0, 0, 10, 1'b0));
        offer_request(pack_request(255, 255, 10, 1'b0));
        offer_request(pack_request(128, 128, 15, 1'b0));
        offer_request(pack_request(128, 128, 11, 1'b0));
        offer_request(pack_request(100, 50, 1, 1'b0));
        offer_request(pack_request(100, 50, 0, 1'b0));
        offer_request(pack_request(100, 50, 5, 1'b1));
        offer_request(pack_request(256, 10, 4, 1'b0));
        offer_request(pack_request(10, 256, 4, 1'b0));
        offer_request(pack_request(-1, 10, 4, 1'b0));
        offer_request(pack_request(10, -4096, 4, 1'b0));
        offer_request(pack_request(4095, 4095, 3, 1'b0));
        offer_request(pack_request(200, 40, 7, 1'b0));

        set_grid(4096, 4096);
        offer_request(pack_request(4095, 4095, 10, 1'b0));
        offer_request(pack_request(4095, 0, 10, 1'b0));
        offer_request(pack_request(0, 4095, 6, 1'b0));

        set_grid(8191, 8191);
        offer_request(pack_request(4095, 2048, 9, 1'b0));
        offer_request(pack_request(-4096, 0, 3, 1'b0));

        set_grid(0, 0);
        offer_request(pack_request(0, 0, 10, 1'b0));

        set_grid(1, 1);
        offer_request(pack_request(0, 0, 10, 1'b0));
        offer_request(pack_request(1, 0, 3, 1'b0));
        offer_request(pack_request(0, 1, 3, 1'b0));

        // long output hold-off while requests keep coming
        set_grid(64, 48);
        stall_pct = 20;
        gap_pct   = 20;
        hold_req  = 1'b1;
        random_phase(64, 48, PHASE_ITEMS);

        gw = $urandom_range(1, 8191);
        gh = $urandom_range(1, 8191);
        set_grid(gw, gh);
        stall_pct = 10;
        gap_pct   = 30;
        random_phase(gw, gh, PHASE_ITEMS);

        set_grid(4096, 4096);
        stall_pct = 40;
        gap_pct   = 5;
        random_phase(4096, 4096, PHASE_ITEMS);

        set_grid(256, 256);
        quiet = 1'b1;
        random_phase(256, 256, PHASE_ITEMS);

        wait_drained(DRAIN_CYCLES);
        $display("Run covered %0d circle requests under %0d grid settings,", requests,
                 grid_settings);
        $display("with input gaps, output stalls and one long output hold-off.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
